FILE: sv/dpar_pkg.sv
// dpar_pkg: shared constants, codes and structs of the pixel area rebinning core
`default_nettype none
package dpar_pkg;

  localparam int GRID_W       = 1024;
  localparam int GRID_H       = 1024;
  localparam int SECTION_COLS = 185;
  localparam int SECTION_ROWS = 388;
  localparam int MAX_SPAN     = 4;

  localparam int CELLS   = GRID_W * GRID_H;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CX_W    = $clog2(GRID_W);
  localparam int CY_W    = $clog2(GRID_H);
  localparam int IDX_W   = (CX_W > CY_W) ? CX_W : CY_W;
  localparam int SPAN_W  = $clog2(MAX_SPAN + 1);
  localparam int COL_W   = $clog2(SECTION_COLS + 1);
  localparam int ROW_W   = $clog2(SECTION_ROWS + 1);

  localparam int APB_ADDR_W = 5;
  localparam int PIX_W      = 32;
  localparam int CELL_IN_W  = 10;
  localparam int VAL_W      = 48;
  localparam int ROT_W      = 18;
  localparam int POS_W      = 32;
  localparam int STEP_W     = 24;
  localparam int DELTA_W    = 27;
  localparam int EXT_W      = 34;
  localparam int W_W        = 17;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ACC      = 2'd0,
    CMD_READ     = 2'd1,
    CMD_READ_CLR = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef logic [W_W-1:0] weight_t;

  typedef struct packed {
    cmd_e                          kind;
    logic signed [PIX_W-1:0]       value;
    logic [IDX_W-1:0]              x_first;
    logic [SPAN_W-1:0]             x_count;
    weight_t [MAX_SPAN-1:0]        x_w;
    logic [IDX_W-1:0]              y_first;
    logic [SPAN_W-1:0]             y_count;
    weight_t [MAX_SPAN-1:0]        y_w;
    logic                          clip;
    logic                          last;
  } job_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] dxx;
    logic signed [DELTA_W-1:0] dxy;
    logic signed [DELTA_W-1:0] ryx_s;
    logic signed [DELTA_W-1:0] ryy_s;
    logic signed [DELTA_W-1:0] ryx_l;
    logic signed [DELTA_W-1:0] ryy_l;
  } steps_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    restart;
  } origin_t;

endpackage
`default_nettype wire

FILE: sv/dpar_ram.sv
// dpar_ram: generic single-port RAM with registered read
`default_nettype none
module dpar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

FILE: sv/dpar_regs.sv
// dpar_regs: configuration registers and rotated step vectors
`default_nettype none
module dpar_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dpar_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output dpar_pkg::steps_t                    steps_o,
  output dpar_pkg::origin_t                   origin_o
);

  typedef enum logic [2:0] {
    REG_ROT_COS    = 3'd0,
    REG_ROT_SIN    = 3'd1,
    REG_ORIGIN_X   = 3'd2,
    REG_ORIGIN_Y   = 3'd3,
    REG_STEP_SHORT = 3'd4,
    REG_STEP_LONG  = 3'd5
  } reg_e;

  logic signed [dpar_pkg::ROT_W-1:0]  rot_cos_q, rot_sin_q;
  logic signed [dpar_pkg::POS_W-1:0]  origin_x_q, origin_y_q;
  logic        [dpar_pkg::STEP_W-1:0] step_short_q, step_long_q;
  logic                               restart_q;
  dpar_pkg::steps_t                   steps_q;
  reg_e                               idx;
  logic                               wr;

  // (rot * step + 0.5) >>> 16
  function automatic logic signed [dpar_pkg::DELTA_W-1:0] rmul(
    input logic signed [dpar_pkg::ROT_W-1:0]  r,
    input logic        [dpar_pkg::STEP_W-1:0] s
  );
    logic signed [dpar_pkg::ROT_W+dpar_pkg::STEP_W:0] p;
    p = r * $signed({1'b0, s}) + 43'sd32768;
    return p[dpar_pkg::ROT_W+dpar_pkg::STEP_W:16];
  endfunction

  assign idx = reg_e'(paddr[dpar_pkg::APB_ADDR_W-1:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_cos_q    <= 18'sd65536;
      rot_sin_q    <= '0;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      step_short_q <= 24'd65536;
      step_long_q  <= 24'd163840;
      restart_q    <= 1'b0;
    end else begin
      restart_q <= wr && (idx == REG_ORIGIN_X || idx == REG_ORIGIN_Y);
      if (wr) begin
        case (idx)
          REG_ROT_COS:    rot_cos_q    <= pwdata[dpar_pkg::ROT_W-1:0];
          REG_ROT_SIN:    rot_sin_q    <= pwdata[dpar_pkg::ROT_W-1:0];
          REG_ORIGIN_X:   origin_x_q   <= pwdata;
          REG_ORIGIN_Y:   origin_y_q   <= pwdata;
          REG_STEP_SHORT: step_short_q <= pwdata[dpar_pkg::STEP_W-1:0];
          REG_STEP_LONG:  step_long_q  <= pwdata[dpar_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // step products, one multiplier each, registered
  always_ff @(posedge clk_i) begin
    steps_q.dxx   <= rmul(rot_cos_q, step_short_q);
    steps_q.dxy   <= rmul(rot_sin_q, step_short_q);
    steps_q.ryx_s <= -rmul(rot_sin_q, step_short_q);
    steps_q.ryy_s <= rmul(rot_cos_q, step_short_q);
    steps_q.ryx_l <= -rmul(rot_sin_q, step_long_q);
    steps_q.ryy_l <= rmul(rot_cos_q, step_long_q);
  end

  always_comb begin
    case (idx)
      REG_ROT_COS:    prdata = 32'(rot_cos_q);
      REG_ROT_SIN:    prdata = 32'(rot_sin_q);
      REG_ORIGIN_X:   prdata = origin_x_q;
      REG_ORIGIN_Y:   prdata = origin_y_q;
      REG_STEP_SHORT: prdata = {8'd0, step_short_q};
      REG_STEP_LONG:  prdata = {8'd0, step_long_q};
      default:        prdata = '0;
    endcase
  end

  assign steps_o          = steps_q;
  assign origin_o.x       = origin_x_q;
  assign origin_o.y       = origin_y_q;
  assign origin_o.restart = restart_q;

endmodule
`default_nettype wire

FILE: sv/dpar_front.sv
// dpar_front: accepts beats, tracks pixel position, builds footprint jobs
`default_nettype none
module dpar_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [1:0]                          cmd_i,
  input  wire logic signed [dpar_pkg::PIX_W-1:0]   pixel_value_i,
  input  wire logic [dpar_pkg::CELL_IN_W-1:0]      cell_x_i,
  input  wire logic [dpar_pkg::CELL_IN_W-1:0]      cell_y_i,
  input  wire dpar_pkg::steps_t                    steps_i,
  input  wire dpar_pkg::origin_t                   origin_i,
  input  wire logic                                clear_done_i,
  input  wire logic                                full_i,
  output logic                                     push_o,
  output dpar_pkg::job_t                           job_o
);

  localparam int IDXS_W = dpar_pkg::EXT_W - 14;
  localparam int CS_W   = dpar_pkg::EXT_W + 2;

  typedef struct packed {
    logic [dpar_pkg::IDX_W-1:0]           first;
    logic [dpar_pkg::SPAN_W-1:0]          count;
    dpar_pkg::weight_t [dpar_pkg::MAX_SPAN-1:0] w;
    logic                                 lost;
  } axis_t;

  typedef enum logic {F_IDLE, F_CALC} fstate_e;

  fstate_e                              state_q;
  dpar_pkg::cmd_e                       cmd_q;
  logic signed [dpar_pkg::PIX_W-1:0]    value_q;
  logic [dpar_pkg::CELL_IN_W-1:0]       cx_q, cy_q;
  logic [dpar_pkg::COL_W-1:0]           col_q;
  logic [dpar_pkg::ROW_W-1:0]           row_q;
  logic signed [dpar_pkg::POS_W-1:0]    cs_x_q, cs_y_q, cor_x_q, cor_y_q;

  logic                                 gap;
  logic signed [dpar_pkg::DELTA_W-1:0]  ryx, ryy;
  logic signed [dpar_pkg::DELTA_W:0]    ex, ey;
  logic signed [dpar_pkg::EXT_W-1:0]    xa, xb, ya, yb, x0, x1, y0, y1;
  logic                                 empty_area;
  axis_t                                ax, ay;
  logic                                 row_end, col_end;
  logic signed [dpar_pkg::POS_W-1:0]    ncs_x, ncs_y, ncor_x, ncor_y;

  function automatic dpar_pkg::weight_t W_Wcut(input logic signed [CS_W-1:0] v);
    return v[dpar_pkg::W_W-1:0];
  endfunction

  // cells overlapped by [lo,hi) along one axis, packed from the first in-range one
  function automatic axis_t axis(
    input logic signed [dpar_pkg::EXT_W-1:0] lo,
    input logic signed [dpar_pkg::EXT_W-1:0] hi,
    input int                                limit
  );
    axis_t                                        r;
    logic signed [IDXS_W-1:0]                     base, idx;
    logic signed [IDXS_W-1:0]                     idxk [dpar_pkg::MAX_SPAN];
    logic signed [CS_W-1:0]                       cs, ce, a, b, tail;
    logic [dpar_pkg::MAX_SPAN-1:0]                hit, inr, vld;
    dpar_pkg::weight_t [dpar_pkg::MAX_SPAN-1:0]   wk;
    int                                           first, sel;
    base = IDXS_W'(lo >>> 16);
    for (int k = 0; k < dpar_pkg::MAX_SPAN; k++) begin
      idx     = base + IDXS_W'(k);
      idxk[k] = idx;
      cs      = CS_W'(idx) <<< 16;
      ce      = cs + CS_W'(65536);
      hit[k]  = cs < CS_W'(hi);
      inr[k]  = (idx >= 0) && (idx < limit);
      vld[k]  = hit[k] && inr[k];
      a       = (CS_W'(lo) > cs) ? CS_W'(lo) : cs;
      b       = (CS_W'(hi) < ce) ? CS_W'(hi) : ce;
      wk[k]   = W_Wcut(b - a);
    end
    first = 0;
    for (int k = dpar_pkg::MAX_SPAN - 1; k >= 0; k--) begin
      if (vld[k]) first = k;
    end
    r.count = dpar_pkg::SPAN_W'($countones(vld));
    r.first = dpar_pkg::IDX_W'(idxk[first]);
    for (int j = 0; j < dpar_pkg::MAX_SPAN; j++) begin
      sel = first + j;
      r.w[j] = (sel < dpar_pkg::MAX_SPAN) ? wk[sel] : '0;
    end
    tail   = CS_W'(base + IDXS_W'(dpar_pkg::MAX_SPAN)) <<< 16;
    r.lost = (|(hit & ~inr)) || (hit[dpar_pkg::MAX_SPAN-1] && (tail < CS_W'(hi)));
    return r;
  endfunction

  // footprint of the current pixel
  always_comb begin
    gap = (row_q == dpar_pkg::ROW_W'(dpar_pkg::SECTION_ROWS / 2 - 1)) ||
          (row_q == dpar_pkg::ROW_W'(dpar_pkg::SECTION_ROWS / 2));
    ryx = gap ? steps_i.ryx_l : steps_i.ryx_s;
    ryy = gap ? steps_i.ryy_l : steps_i.ryy_s;
    ex  = (dpar_pkg::DELTA_W+1)'(steps_i.dxx) + (dpar_pkg::DELTA_W+1)'(ryx);
    ey  = (dpar_pkg::DELTA_W+1)'(steps_i.dxy) + (dpar_pkg::DELTA_W+1)'(ryy);
    xa  = dpar_pkg::EXT_W'(cor_x_q);
    xb  = xa + dpar_pkg::EXT_W'(ex);
    ya  = dpar_pkg::EXT_W'(cor_y_q);
    yb  = ya + dpar_pkg::EXT_W'(ey);
    x0  = (xb < xa) ? xb : xa;
    x1  = (xb < xa) ? xa : xb;
    y0  = (yb < ya) ? yb : ya;
    y1  = (yb < ya) ? ya : yb;
    empty_area = (x1 <= x0) || (y1 <= y0);
    ax  = axis(x0, x1, dpar_pkg::GRID_W);
    ay  = axis(y0, y1, dpar_pkg::GRID_H);
  end

  // position advance
  always_comb begin
    row_end = (32'(row_q) + 32'd1) >= 32'(dpar_pkg::SECTION_ROWS);
    col_end = (32'(col_q) + 32'd1) >= 32'(dpar_pkg::SECTION_COLS);
    ncs_x   = cs_x_q + dpar_pkg::POS_W'(steps_i.dxx);
    ncs_y   = cs_y_q + dpar_pkg::POS_W'(steps_i.dxy);
    ncor_x  = cor_x_q + dpar_pkg::POS_W'(ryx);
    ncor_y  = cor_y_q + dpar_pkg::POS_W'(ryy);
  end

  always_comb begin
    job_o       = '0;
    job_o.value = value_q;
    case (cmd_q)
      dpar_pkg::CMD_ACC: begin
        job_o.kind = dpar_pkg::CMD_ACC;
        job_o.last = row_end && col_end;
        if (!empty_area) begin
          job_o.x_first = ax.first;
          job_o.x_count = ax.count;
          job_o.x_w     = ax.w;
          job_o.y_first = ay.first;
          job_o.y_count = ay.count;
          job_o.y_w     = ay.w;
          job_o.clip    = ax.lost || ay.lost;
        end
      end
      dpar_pkg::CMD_READ, dpar_pkg::CMD_READ_CLR: begin
        job_o.kind    = ((32'(cx_q) < 32'(dpar_pkg::GRID_W)) &&
                         (32'(cy_q) < 32'(dpar_pkg::GRID_H))) ? cmd_q : dpar_pkg::CMD_NONE;
        job_o.x_first = dpar_pkg::IDX_W'(cx_q);
        job_o.y_first = dpar_pkg::IDX_W'(cy_q);
      end
      default: job_o.kind = dpar_pkg::CMD_NONE;
    endcase
  end

  assign push_o     = (state_q == F_CALC) && !full_i;
  assign in_ready_o = (state_q == F_IDLE) && clear_done_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      cs_x_q  <= '0;
      cs_y_q  <= '0;
      cor_x_q <= '0;
      cor_y_q <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (origin_i.restart) begin
            col_q   <= '0;
            row_q   <= '0;
            cs_x_q  <= origin_i.x;
            cs_y_q  <= origin_i.y;
            cor_x_q <= origin_i.x;
            cor_y_q <= origin_i.y;
          end
          if (in_valid_i && in_ready_o) state_q <= F_CALC;
        end
        F_CALC: begin
          if (!full_i) begin
            state_q <= F_IDLE;
            if (cmd_q == dpar_pkg::CMD_ACC) begin
              if (row_end) begin
                row_q <= '0;
                if (col_end) begin
                  col_q   <= '0;
                  cs_x_q  <= origin_i.x;
                  cs_y_q  <= origin_i.y;
                  cor_x_q <= origin_i.x;
                  cor_y_q <= origin_i.y;
                end else begin
                  col_q   <= col_q + 1'b1;
                  cs_x_q  <= ncs_x;
                  cs_y_q  <= ncs_y;
                  cor_x_q <= ncs_x;
                  cor_y_q <= ncs_y;
                end
              end else begin
                row_q   <= row_q + 1'b1;
                cor_x_q <= ncor_x;
                cor_y_q <= ncor_y;
              end
            end
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= dpar_pkg::cmd_e'(cmd_i);
      value_q <= pixel_value_i;
      cx_q    <= cell_x_i;
      cy_q    <= cell_y_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/dpar_fifo.sv
// dpar_fifo: short job queue between front and back
`default_nettype none
module dpar_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dpar_pkg::job_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output dpar_pkg::job_t      data_o
);

  localparam int PTR_W = (dpar_pkg::FIFO_DEPTH > 1) ? $clog2(dpar_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(dpar_pkg::FIFO_DEPTH + 1);

  dpar_pkg::job_t     mem_q [dpar_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;

  assign full_o  = cnt_q == CNT_W'(dpar_pkg::FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (32'(p) == dpar_pkg::FIFO_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= bump(wr_q);
      if (pop_i)  rd_q <= bump(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

FILE: sv/dpar_back.sv
// dpar_back: grid memory sweep, cell read-modify-write and result register
`default_nettype none
module dpar_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            empty_i,
  input  wire dpar_pkg::job_t                  job_i,
  output logic                                 pop_o,
  output logic                                 clear_done_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [dpar_pkg::VAL_W-1:0]    cell_value_o,
  output logic                                 clipped_o,
  output logic                                 last_o
);

  localparam int P1_W = dpar_pkg::PIX_W + dpar_pkg::W_W + 1;
  localparam int Q_W  = P1_W + dpar_pkg::W_W + 1;
  localparam int C_W  = Q_W - 24;
  localparam int S_W  = dpar_pkg::VAL_W + 1;
  localparam int SEL_W = $clog2(dpar_pkg::MAX_SPAN);

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_ACC_RD, B_ACC_MUL, B_ACC_WR, B_READ, B_READ_DATA, B_EMIT
  } bstate_e;

  bstate_e                              state_q;
  dpar_pkg::job_t                       job_q;
  logic [dpar_pkg::ADDR_W-1:0]          clr_q;
  logic [dpar_pkg::SPAN_W-1:0]          a_q, b_q;
  logic signed [P1_W-1:0]               p1_q;
  logic signed [Q_W-1:0]                q_q;
  logic signed [dpar_pkg::VAL_W-1:0]    res_q;
  logic                                 out_valid_q, out_clip_q, out_last_q;
  logic signed [dpar_pkg::VAL_W-1:0]    out_val_q;

  logic                                 ram_we, ram_re;
  logic [dpar_pkg::ADDR_W-1:0]          ram_addr, cell_addr;
  logic [dpar_pkg::VAL_W-1:0]           ram_wdata, ram_rdata;
  logic signed [C_W-1:0]                contrib;
  logic signed [S_W-1:0]                sum;
  logic signed [dpar_pkg::VAL_W-1:0]    sat_sum;
  logic                                 out_free, a_last, b_last;
  logic [dpar_pkg::IDX_W:0]             xi, yi;

  dpar_ram #(
    .WIDTH (dpar_pkg::VAL_W),
    .DEPTH (dpar_pkg::CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    xi        = (dpar_pkg::IDX_W+1)'(job_q.x_first) + (dpar_pkg::IDX_W+1)'(a_q);
    yi        = (dpar_pkg::IDX_W+1)'(job_q.y_first) + (dpar_pkg::IDX_W+1)'(b_q);
    cell_addr = dpar_pkg::ADDR_W'(dpar_pkg::ADDR_W'(yi) * dpar_pkg::GRID_W +
                                  dpar_pkg::ADDR_W'(xi));
    contrib   = C_W'((q_q + Q_W'(1 << 23)) >>> 24);
    sum       = S_W'($signed(ram_rdata)) + S_W'(contrib);
    if (sum[S_W-1] != sum[S_W-2]) begin
      sat_sum = sum[S_W-1] ? {1'b1, {(dpar_pkg::VAL_W-1){1'b0}}}
                           : {1'b0, {(dpar_pkg::VAL_W-1){1'b1}}};
    end else begin
      sat_sum = sum[dpar_pkg::VAL_W-1:0];
    end
    a_last   = (32'(a_q) + 32'd1) >= 32'(job_q.x_count);
    b_last   = (32'(b_q) + 32'd1) >= 32'(job_q.y_count);
    out_free = !out_valid_q || out_ready_i;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = cell_addr;
    ram_wdata = '0;
    case (state_q)
      B_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
      end
      B_ACC_RD, B_READ: ram_re = 1'b1;
      B_ACC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = sat_sum;
      end
      B_READ_DATA: ram_we = job_q.kind == dpar_pkg::CMD_READ_CLR;
      default: ;
    endcase
  end

  assign pop_o        = (state_q == B_IDLE) && !empty_i;
  assign clear_done_o = state_q != B_CLEAR;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // held until taken; loaded when a result leaves the emit state
      out_valid_q <= (out_valid_q && !out_ready_i) || ((state_q == B_EMIT) && out_free);
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == dpar_pkg::CELLS - 1) state_q <= B_IDLE;
        end
        B_IDLE: begin
          a_q <= '0;
          b_q <= '0;
          if (!empty_i) begin
            case (job_i.kind)
              dpar_pkg::CMD_ACC:
                state_q <= (job_i.x_count == '0 || job_i.y_count == '0) ? B_EMIT : B_ACC_RD;
              dpar_pkg::CMD_READ, dpar_pkg::CMD_READ_CLR: state_q <= B_READ;
              default: state_q <= B_EMIT;
            endcase
          end
        end
        B_ACC_RD:  state_q <= B_ACC_MUL;
        B_ACC_MUL: state_q <= B_ACC_WR;
        B_ACC_WR: begin
          if (a_last) begin
            a_q <= '0;
            if (b_last) state_q <= B_EMIT;
            else begin
              b_q     <= b_q + 1'b1;
              state_q <= B_ACC_RD;
            end
          end else begin
            a_q     <= a_q + 1'b1;
            state_q <= B_ACC_RD;
          end
        end
        B_READ:      state_q <= B_READ_DATA;
        B_READ_DATA: state_q <= B_EMIT;
        B_EMIT: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      res_q <= '0;
    end
    if (state_q == B_ACC_RD) begin
      p1_q <= P1_W'(job_q.value * $signed({1'b0, job_q.x_w[a_q[SEL_W-1:0]]}));
    end
    if (state_q == B_ACC_MUL) begin
      q_q <= Q_W'(p1_q * $signed({1'b0, job_q.y_w[b_q[SEL_W-1:0]]}));
    end
    if (state_q == B_READ_DATA) res_q <= ram_rdata;
    if (state_q == B_EMIT && out_free) begin
      out_val_q  <= res_q;
      out_clip_q <= job_q.clip;
      out_last_q <= job_q.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_val_q;
  assign clipped_o    = out_clip_q;
  assign last_o       = out_last_q;

endmodule
`default_nettype wire

FILE: sv/detector_pixel_area_rebinning_core.sv
// Flow: the front registers an accepted beat, builds its job and pushes it into a 2-deep
// queue; the back pops it and runs read, multiply and write states per covered grid
// cell, or read and read-data states for a cell read, then loads the result register.
// The single-port grid memory does one read-modify-write per cell at a time; the front
// takes a new beat only once its last job is pushed. Reset: control state clears at once,
// then the grid memory is zeroed one cell a cycle, no beat taken (APB writes still work).
// detector_pixel_area_rebinning_core: top level of the area-weighted rebinning block
`default_nettype none
module detector_pixel_area_rebinning_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // APB configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [dpar_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  // input beats
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [55:0]                     s_axis_tdata, // pixel_value, cell_x, cell_y
  input  wire logic [1:0]                      s_axis_tuser, // cmd
  // result beats
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [47:0]                          m_axis_tdata, // cell_value
  output logic [0:0]                           m_axis_tuser, // clipped
  output logic                                 m_axis_tlast  // section_last
);

  dpar_pkg::steps_t  steps;
  dpar_pkg::origin_t origin;
  dpar_pkg::job_t    push_job, pop_job;
  logic              push, pop, full, empty, clear_done;
  logic              clipped, last;
  logic signed [dpar_pkg::VAL_W-1:0] cell_value;

  assign pready = 1'b1;

  // registers and the rotated step vectors derived from them
  dpar_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .steps_o  (steps),
    .origin_o (origin)
  );

  // front: decode beat, walk the pixel grid, work out footprint cells and weights
  dpar_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .pixel_value_i (s_axis_tdata[31:0]),
    .cell_x_i      (s_axis_tdata[41:32]),
    .cell_y_i      (s_axis_tdata[51:42]),
    .steps_i       (steps),
    .origin_i      (origin),
    .clear_done_i  (clear_done),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  // jobs queue so the front can run ahead of the memory work
  dpar_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_job)
  );

  // back: grid memory, weighted saturating accumulate, cell reads, output register
  dpar_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .job_i        (pop_job),
    .pop_o        (pop),
    .clear_done_o (clear_done),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .cell_value_o (cell_value),
    .clipped_o    (clipped),
    .last_o       (last)
  );

  assign m_axis_tdata    = cell_value;
  assign m_axis_tuser[0] = clipped;
  assign m_axis_tlast    = last;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// testbench: self-checking bench for the area-weighted pixel rebinning core
`default_nettype none
module testbench;

  localparam int WD_LIMIT = 4000000;  // covers the grid sweep after reset several times over
  localparam int HOLD_CYC = 400;

  typedef enum int {
    REG_ROT_COS = 0, REG_ROT_SIN = 1, REG_ORIGIN_X = 2,
    REG_ORIGIN_Y = 3, REG_STEP_SHORT = 4, REG_STEP_LONG = 5
  } reg_e;

  typedef struct packed {
    logic [47:0] val;
    logic        clip;
    logic        last;
  } beat_t;

  typedef struct packed {
    dpar_pkg::cmd_e k;
    logic [31:0]    v;
    logic [9:0]     x;
    logic [9:0]     y;
    logic           typed;
    beat_t          want;
  } row_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [dpar_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic s_tvalid = 1'b0, s_tready;
  logic [55:0] s_tdata = '0;   // pixel_value[31:0], cell_x[41:32], cell_y[51:42], pad
  logic [1:0] s_tuser = '0;    // cmd
  logic m_tvalid, m_tready = 1'b0;
  logic [47:0] m_tdata;        // cell_value
  logic [0:0] m_tuser;         // clipped
  logic m_tlast;               // section_last

  detector_pixel_area_rebinning_core dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // ---- predictor state: configuration, walk position, grid sums ----
  longint cfg_cos = 65536, cfg_sin = 0, cfg_ox = 0, cfg_oy = 0;
  longint cfg_ss = 65536, cfg_sl = 163840;
  int unsigned walk_col = 0, walk_row = 0;
  longint colstart_x = 0, colstart_y = 0, pos_x = 0, pos_y = 0;
  longint cell_sum [int];

  beat_t due_q [$];
  int errors = 0;
  bit calm = 1'b0;        // no idling on either side while set
  int hold_seq = 0;       // bump to make the receiver hold off

  function automatic longint wrap32(longint v);
    int t;
    t = v[31:0];
    return t;
  endfunction

  // rotated step component, rounding half up
  function automatic longint rot_step(longint r, longint s);
    return (r * s + 32768) >>> 16;
  endfunction

  function automatic void span_cells(input longint lo, input longint hi, input longint lim,
                                     output int n,
                                     output longint idx [dpar_pkg::MAX_SPAN],
                                     output longint w [dpar_pkg::MAX_SPAN], output bit lost);
    longint base, i, cs, a, b;
    int k;
    n = 0;
    lost = 1'b0;
    base = lo >>> 16;
    for (k = 0; k < dpar_pkg::MAX_SPAN; k++) begin
      i = base + k;
      cs = i * 65536;
      if (cs >= hi) break;
      a = (lo > cs) ? lo : cs;
      b = (hi < cs + 65536) ? hi : cs + 65536;
      if (i < 0 || i >= lim) lost = 1'b1;
      else begin
        idx[n] = i;
        w[n] = b - a;
        n++;
      end
    end
    // footprint wider than the visited span
    if (k == dpar_pkg::MAX_SPAN && (base + dpar_pkg::MAX_SPAN) * 65536 < hi) lost = 1'b1;
  endfunction

  function automatic bit deposit(longint val, longint ex, longint ey);
    longint x0, x1, y0, y1, t, q, c, s, old;
    longint xi [dpar_pkg::MAX_SPAN], xw [dpar_pkg::MAX_SPAN];
    longint yi [dpar_pkg::MAX_SPAN], yw [dpar_pkg::MAX_SPAN];
    int nx, ny, key;
    bit lx, ly;
    x0 = pos_x; x1 = pos_x + ex;
    y0 = pos_y; y1 = pos_y + ey;
    if (x1 < x0) begin t = x0; x0 = x1; x1 = t; end
    if (y1 < y0) begin t = y0; y0 = y1; y1 = t; end
    if (x1 <= x0 || y1 <= y0) return 1'b0;   // zero area: nothing added, not clipped
    span_cells(x0, x1, dpar_pkg::GRID_W, nx, xi, xw, lx);
    span_cells(y0, y1, dpar_pkg::GRID_H, ny, yi, yw, ly);
    for (int b = 0; b < ny; b++)
      for (int a = 0; a < nx; a++) begin
        q = (val * xw[a]) * yw[b];
        c = (q + (longint'(1) << 23)) >>> 24;
        key = int'(yi[b] * dpar_pkg::GRID_W + xi[a]);
        old = cell_sum.exists(key) ? cell_sum[key] : 0;
        s = old + c;
        if (s > 64'sd140737488355327) s = 64'sd140737488355327;
        if (s < -64'sd140737488355328) s = -64'sd140737488355328;
        cell_sum[key] = s;
      end
    return lx || ly;
  endfunction

  function automatic void restart_walk();
    walk_col = 0; walk_row = 0;
    colstart_x = cfg_ox; colstart_y = cfg_oy;
    pos_x = cfg_ox; pos_y = cfg_oy;
  endfunction

  function automatic beat_t rebin_step(dpar_pkg::cmd_e k, logic [31:0] v, logic [9:0] x,
                                       logic [9:0] y);
    beat_t r;
    longint dxx, dxy, ryx, ryy, rs, cur;
    int key;
    bit gap;
    r = '0;
    case (k)
      dpar_pkg::CMD_ACC: begin
        dxx = rot_step(cfg_cos, cfg_ss);
        dxy = rot_step(cfg_sin, cfg_ss);
        // the two middle rows use the long pitch
        gap = (walk_row == dpar_pkg::SECTION_ROWS / 2 - 1) ||
              (walk_row == dpar_pkg::SECTION_ROWS / 2);
        rs = gap ? cfg_sl : cfg_ss;
        ryx = -rot_step(cfg_sin, rs);
        ryy = rot_step(cfg_cos, rs);
        r.clip = deposit(longint'($signed(v)), dxx + ryx, dxy + ryy);
        if (walk_row + 1 >= dpar_pkg::SECTION_ROWS) begin
          if (walk_col + 1 >= dpar_pkg::SECTION_COLS) begin
            r.last = 1'b1;
            restart_walk();
          end else begin
            walk_col++;
            walk_row = 0;
            colstart_x = wrap32(colstart_x + dxx);
            colstart_y = wrap32(colstart_y + dxy);
            pos_x = colstart_x;
            pos_y = colstart_y;
          end
        end else begin
          walk_row++;
          pos_x = wrap32(pos_x + ryx);
          pos_y = wrap32(pos_y + ryy);
        end
      end
      dpar_pkg::CMD_READ, dpar_pkg::CMD_READ_CLR: begin
        key = int'(y) * dpar_pkg::GRID_W + int'(x);
        cur = cell_sum.exists(key) ? cell_sum[key] : 0;
        r.val = cur[47:0];
        if (k == dpar_pkg::CMD_READ_CLR) cell_sum.delete(key);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---- result side: random stalls, plus long hold-offs on request ----
  initial begin : rx_side
    int seen, hold;
    seen = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold = HOLD_CYC;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else m_tready <= calm || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    beat_t w;
    if (m_tvalid && m_tready) begin
      if (due_q.size() == 0) begin
        $display("%0t: result beat with nothing due, got %0d/%0b/%0b", $time,
                 $signed(m_tdata), m_tuser, m_tlast);
        errors++;
      end else begin
        w = due_q.pop_front();
        if (m_tdata !== w.val) begin
          $display("%0t: cell_value expected %0d actual %0d", $time,
                   $signed(w.val), $signed(m_tdata));
          errors++;
        end
        if (m_tuser[0] !== w.clip) begin
          $display("%0t: clipped expected %0b actual %0b", $time, w.clip, m_tuser[0]);
          errors++;
        end
        if (m_tlast !== w.last) begin
          $display("%0t: section_last expected %0b actual %0b", $time, w.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat or APB access
  always @(posedge clk) begin : watchdog
    int quiet;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) quiet = 0;
    else quiet++;
    if (quiet >= WD_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---- stimulus helpers ----
  task automatic send_beat(dpar_pkg::cmd_e k, logic [31:0] v, logic [9:0] x, logic [9:0] y,
                           bit typed = 1'b0, beat_t want = '0);
    beat_t r;
    @(negedge clk);
    while (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, y, x, v};
    s_tuser <= k;
    do @(posedge clk); while (!s_tready);
    r = rebin_step(k, v, x, y);
    due_q.push_back(typed ? want : r);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(reg_e idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= dpar_pkg::APB_ADDR_W'(int'(idx) * 4); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROT_COS:    cfg_cos = longint'($signed(val[17:0]));
      REG_ROT_SIN:    cfg_sin = longint'($signed(val[17:0]));
      REG_ORIGIN_X:   begin cfg_ox = longint'($signed(val)); restart_walk(); end
      REG_ORIGIN_Y:   begin cfg_oy = longint'($signed(val)); restart_walk(); end
      REG_STEP_SHORT: cfg_ss = longint'(val[23:0]);
      REG_STEP_LONG:  cfg_sl = longint'(val[23:0]);
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_rot();
    case ($urandom_range(5))
      0: return 32'sd65536;
      1: return -32'sd65536;
      2: return 32'd0;
      default: return $urandom_range(131072) - 65536;
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return -($urandom_range(4 << 16));
      default: return $urandom_range(1000 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(3 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // read a cell near the walk position most of the time, so sums are seen
  task automatic read_near(dpar_pkg::cmd_e k);
    int bx, by;
    if ($urandom_range(9) < 7) begin
      bx = int'(pos_x >>> 16) + $urandom_range(4) - 2;
      by = int'(pos_y >>> 16) + $urandom_range(4) - 2;
      send_beat(k, $urandom, 10'(bx), 10'(by));
    end else send_beat(k, $urandom, 10'($urandom), 10'($urandom));
  endtask

  // Directed rows, default registers: corner at cell (0,0), one-cell square footprint
  // stepping down one cell per row, so a cell gets value*256, the value in Q40.8.
  row_t plan [14];

  initial begin
    plan = '{
      '{dpar_pkg::CMD_READ,     32'd0,         10'd0,    10'd0,    1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_READ,     32'd0,         10'd1023, 10'd1023, 1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_NONE,     32'hFFFF_FFFF, 10'h3FF,  10'h3FF,  1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_ACC,      32'd100,       10'd0,    10'd0,    1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_READ,     32'd0,         10'd0,    10'd0,    1'b1,
        '{48'd25600, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_ACC,      32'h7FFF_FFFF, 10'd0,    10'd0,    1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_ACC,      32'h8000_0000, 10'd0,    10'd0,    1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_READ_CLR, 32'd0,         10'd0,    10'd1,    1'b1,
        '{48'sd549755813632, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_READ,     32'd0,         10'd0,    10'd1,    1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_READ_CLR, 32'd0,         10'd0,    10'd2,    1'b1,
        '{-48'sd549755813888, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_READ,     32'd0,         10'd0,    10'd2,    1'b1,
        '{48'd0, 1'b0, 1'b0}},
      '{dpar_pkg::CMD_ACC,      32'hFFFF_FFFF, 10'd0,    10'd0,    1'b0, '0},
      '{dpar_pkg::CMD_ACC,      32'h0000_0001, 10'd0,    10'd0,    1'b0, '0},
      '{dpar_pkg::CMD_READ_CLR, 32'd0,         10'd0,    10'd3,    1'b0, '0}
    };
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed part; first beat waits out the clearing sweep after reset
    foreach (plan[i])
      send_beat(plan[i].k, plan[i].v, plan[i].x, plan[i].y, plan[i].typed, plan[i].want);
    drain();

    // saturation: restart on one cell and pile full-scale values on it
    for (int i = 0; i < 258; i++) begin
      reg_write(REG_ORIGIN_X, 32'd0);
      send_beat(dpar_pkg::CMD_ACC, 32'h7FFF_FFFF, 10'd0, 10'd0);
      drain();
    end
    send_beat(dpar_pkg::CMD_READ_CLR, 32'd0, 10'd0, 10'd0);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 1);
      reg_write(REG_ROT_COS, pick_rot());
      reg_write(REG_ROT_SIN, pick_rot());
      reg_write(REG_STEP_SHORT, pick_step());
      reg_write(REG_STEP_LONG, pick_step());
      reg_write(REG_ORIGIN_X, pick_origin());
      reg_write(REG_ORIGIN_Y, pick_origin());
      if (ph == 2) hold_seq++;   // receiver stalls while beats keep coming
      for (int n = 0; n < 30; n++) begin
        case ($urandom_range(7))
          0: read_near(dpar_pkg::CMD_READ);
          1: read_near(dpar_pkg::CMD_READ_CLR);
          default: send_beat(dpar_pkg::CMD_ACC, pick_value(), 10'($urandom), 10'($urandom));
        endcase
      end
      drain();
    end
    calm = 1'b0;

    repeat (60) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
